// ===== hw/rtl/fptdt_pkg.sv =====
// Shared types, constants and helpers for the fixed-point to decimal text block.
package fptdt_pkg;

  // Fixed widths of the external fields
  localparam int VALUE_W  = 48;
  localparam int CHAR_W   = 8;
  localparam int KREG_W   = 4;
  localparam int ADDR_W   = 3;
  localparam int PDATA_W  = 32;

  // Binary to BCD conversion consumes this many bits per cycle
  localparam int DABBLE_BITS = 4;

  // Register map
  localparam logic REG_FRACTION_DIGITS = 1'b0;
  localparam logic [KREG_W-1:0] FRACTION_DIGITS_RESET = 4'd2;

  // ASCII codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

  // Character source selected by the controller
  typedef enum logic [1:0] {
    SEL_INT  = 2'd0,
    SEL_DOT  = 2'd1,
    SEL_FRAC = 2'd2
  } sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic conv_step;
    logic prep;
    logic int_next;
    logic frac_next;
    sel_t sel;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_done;
    logic int_last;
    logic frac_last;
    logic frac_none;
  } status_t;

  // Number of decimal digits needed for an unsigned value of the given width
  function automatic int dec_digits(input int bits);
    longint unsigned lim;
    longint unsigned p;
    int d;
    lim = (64'd1 << bits) - 64'd1;
    p = 64'd10;
    d = 1;
    while (p <= lim) begin
      d = d + 1;
      p = p * 64'd10;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/fptdt_datapath.sv =====
// Datapath: BCD conversion of the integer part, fraction digit extraction, character mux.
module fptdt_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic [fptdt_pkg::VALUE_W-1:0]      value,
  input  logic [fptdt_pkg::KREG_W-1:0]       frac_digits,
  input  fptdt_pkg::cmd_t                    cmd,
  output fptdt_pkg::status_t                 status,
  output logic [fptdt_pkg::CHAR_W-1:0]       character
);
  import fptdt_pkg::*;

  localparam int IW    = VALUE_W - FRACTION_BITS;
  localparam int STEPS = (IW + DABBLE_BITS - 1) / DABBLE_BITS;
  localparam int PW    = STEPS * DABBLE_BITS;
  localparam int IDIG  = dec_digits(IW);
  localparam int BW    = 4 * IDIG;
  localparam int SCW   = $clog2(STEPS);
  localparam int PTW   = $clog2(IDIG);

  logic [PW-1:0]            bin;
  logic [BW-1:0]            bcd;
  logic [SCW-1:0]           step_cnt;
  logic [PTW-1:0]           ptr;
  logic [FRACTION_BITS-1:0] frac;
  logic [KREG_W-1:0]        frac_cnt;

  logic [PW-1:0]              bin_dab;
  logic [BW-1:0]              bcd_dab;
  logic [PTW-1:0]             ptr_first;
  logic [3:0]                 int_digit;
  logic [FRACTION_BITS+3:0]   frac_x10;
  logic [3:0]                 frac_digit;

  // Double dabble, several bits per cycle
  always_comb begin
    bcd_dab = bcd;
    bin_dab = bin;
    for (int s = 0; s < DABBLE_BITS; s++) begin
      for (int d = 0; d < IDIG; d++) begin
        if (bcd_dab[4*d +: 4] >= 4'd5) begin
          bcd_dab[4*d +: 4] = bcd_dab[4*d +: 4] + 4'd3;
        end
      end
      bcd_dab = {bcd_dab[BW-2:0], bin_dab[PW-1]};
      bin_dab = {bin_dab[PW-2:0], 1'b0};
    end
  end

  // Most significant nonzero digit; digit zero when the value is zero
  always_comb begin
    ptr_first = '0;
    for (int d = 0; d < IDIG; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        ptr_first = PTW'(d);
      end
    end
  end

  // Next fraction digit: fraction times ten, split at the binary point
  assign frac_x10   = ({4'd0, frac} << 3) + ({4'd0, frac} << 1);
  assign frac_digit = frac_x10[FRACTION_BITS+3:FRACTION_BITS];
  assign int_digit  = bcd[4*ptr +: 4];

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= PW'(value[VALUE_W-1:FRACTION_BITS]);
      bcd      <= '0;
      step_cnt <= '0;
      frac     <= value[FRACTION_BITS-1:0];
      frac_cnt <= frac_digits;
    end
    if (cmd.conv_step) begin
      bin      <= bin_dab;
      bcd      <= bcd_dab;
      step_cnt <= step_cnt + SCW'(1);
    end
    if (cmd.prep) begin
      ptr <= ptr_first;
    end
    if (cmd.int_next) begin
      ptr <= ptr - PTW'(1);
    end
    if (cmd.frac_next) begin
      frac     <= frac_x10[FRACTION_BITS-1:0];
      frac_cnt <= frac_cnt - KREG_W'(1);
    end
  end

  // Status back to the controller
  assign status.conv_done = (step_cnt == SCW'(STEPS - 1));
  assign status.int_last  = (ptr == '0);
  assign status.frac_last = (frac_cnt == 4'd1);
  assign status.frac_none = (frac_cnt == 4'd0);

  // Character select
  always_comb begin
    unique case (cmd.sel)
      SEL_INT:  character = ASCII_ZERO + {4'd0, int_digit};
      SEL_FRAC: character = ASCII_ZERO + {4'd0, frac_digit};
      default:  character = ASCII_DOT;
    endcase
  end

endmodule

// ===== hw/rtl/fptdt_ctrl.sv =====
// Controller state machine: sequences conversion and character output.
module fptdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                last,
  input  fptdt_pkg::status_t  status,
  output fptdt_pkg::cmd_t     cmd
);
  import fptdt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_PREP = 6'b000100,
    ST_INT  = 6'b001000,
    ST_DOT  = 6'b010000,
    ST_FRAC = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_fire;

  assign out_fire = out_valid && out_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.sel       = SEL_INT;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    last          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_done) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_INT;
      end
      ST_INT: begin
        out_valid = 1'b1;
        last      = status.int_last && status.frac_none;
        if (out_fire) begin
          cmd.int_next = 1'b1;
          if (status.int_last) begin
            state_next = status.frac_none ? ST_IDLE : ST_DOT;
          end
        end
      end
      ST_DOT: begin
        out_valid = 1'b1;
        cmd.sel   = SEL_DOT;
        if (out_fire) begin
          state_next = ST_FRAC;
        end
      end
      ST_FRAC: begin
        out_valid = 1'b1;
        cmd.sel   = SEL_FRAC;
        last      = status.frac_last;
        if (out_fire) begin
          cmd.frac_next = 1'b1;
          if (status.frac_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/fixed_point_to_decimal_text.sv =====
// Top level: APB register, controller and datapath for decimal text output.
// Sequence: accept the number, BCD conversion of the integer part four bits at a time,
// find the leading digit, then one character per cycle while out_ready is high.
// A new number is accepted only once the last character of the previous one is taken.
// Reset (rst, synchronous): controller idle, fraction_digits back to 2.
module fixed_point_to_decimal_text #(
  parameter int FRACTION_BITS       = 16,
  parameter int MAX_FRACTION_DIGITS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fptdt_pkg::ADDR_W-1:0]      paddr,
  input  logic [fptdt_pkg::PDATA_W-1:0]     pwdata,
  output logic [fptdt_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fptdt_pkg::VALUE_W-1:0]     value,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fptdt_pkg::CHAR_W-1:0]      character,
  output logic                              last
);
  import fptdt_pkg::*;

  logic [KREG_W-1:0] fraction_digits;
  logic [KREG_W-1:0] k_sat;
  logic              reg_sel;
  cmd_t              cmd;
  status_t           status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_FRACTION_DIGITS);

  // Register write on the access phase of a transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits <= FRACTION_DIGITS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      fraction_digits <= pwdata[KREG_W-1:0];
    end
  end

  // Read back
  assign prdata = reg_sel ? PDATA_W'(fraction_digits) : '0;

  // Saturate the digit count
  assign k_sat = (fraction_digits > KREG_W'(MAX_FRACTION_DIGITS)) ?
                 KREG_W'(MAX_FRACTION_DIGITS) : fraction_digits;

  fptdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last),
    .status    (status),
    .cmd       (cmd)
  );

  fptdt_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .value       (value),
    .frac_digits (k_sat),
    .cmd         (cmd),
    .status      (status),
    .character   (character)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for fixed_point_to_decimal_text: directed table, then random numbers checked per character.
`timescale 1ns / 100ps

module tb;
  import fptdt_pkg::*;

  localparam int FRACTION_BITS       = 16;
  localparam int MAX_FRACTION_DIGITS = 9;
  localparam int TEXT_MAX            = 20;
  localparam int DRAIN_CYCLES        = 16;
  localparam int CYCLE_LIMIT         = 2_000_000;
  localparam int RANDOM_PHASES       = 6;
  localparam int PHASE_NUMBERS       = 75;
  localparam int HOLD_OFF_CYCLES     = 400;
  localparam int HOLD_OFF_AFTER      = 1500;
  localparam int DIRECTED_ROWS       = 23;
  localparam logic [ADDR_W-1:0] FRACTION_DIGITS_ADDR = {REG_FRACTION_DIGITS, 2'b00};

  typedef logic [8*TEXT_MAX-1:0] text_t;

  // one row of the directed table; an all-zero text means "use the predictor"
  typedef struct packed {
    logic [KREG_W-1:0]  digits;
    logic [VALUE_W-1:0] number;
    text_t              text;
  } number_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  localparam number_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{4'd2,  48'h0000_0000_0000, text_t'("0.00")},
    '{4'd2,  48'hFFFF_FFFF_FFFF, text_t'("4294967295.99")},
    '{4'd2,  48'h0000_0001_0000, text_t'("1.00")},
    '{4'd2,  48'h0000_0000_8000, text_t'("0.50")},
    '{4'd2,  48'h0000_0009_FFFF, '0},
    '{4'd2,  48'h0000_000A_0000, '0},
    '{4'd0,  48'h0000_0000_0000, text_t'("0")},
    '{4'd0,  48'hFFFF_FFFF_FFFF, text_t'("4294967295")},
    '{4'd0,  48'h0000_000A_FFFF, text_t'("10")},
    '{4'd0,  48'h3B9A_C9FF_FFFF, '0},
    '{4'd0,  48'h3B9A_CA00_0000, '0},
    '{4'd9,  48'h0000_0000_FFFF, text_t'("0.999984741")},
    '{4'd9,  48'hFFFF_FFFF_FFFF, text_t'("4294967295.999984741")},
    '{4'd9,  48'h0000_0000_0001, text_t'("0.000015258")},
    '{4'd9,  48'h0000_0001_0001, '0},
    '{4'd15, 48'h0000_0000_0001, text_t'("0.000015258")},
    '{4'd15, 48'h0000_0000_0000, text_t'("0.000000000")},
    '{4'd10, 48'hFFFF_FFFF_0000, text_t'("4294967295.000000000")},
    '{4'd1,  48'h0000_0001_8000, text_t'("1.5")},
    '{4'd1,  48'h0000_0063_1999, '0},
    '{4'd1,  48'h0000_0064_E666, '0},
    '{4'd3,  48'h0000_3039_0ABC, '0},
    '{4'd3,  48'h0000_0000_0000, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [VALUE_W-1:0]   value;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAR_W-1:0]    character;
  logic                 last;

  // predictor's copy of the register
  logic [KREG_W-1:0]    frac_digits = FRACTION_DIGITS_RESET;
  // characters still owed by the block, oldest first
  text_char_t           expected_text [$];
  logic [CHAR_W-1:0]    text_buf [TEXT_MAX];
  int                   text_len;

  int                   err_count = 0;
  int                   checked_chars = 0;
  int                   cycle_count = 0;
  bit                   tx_gaps_on = 1'b1;
  bit                   rx_stalls_on = 1'b1;
  bit                   hold_done = 1'b0;
  int                   hold_left = 0;
  int                   stall_left = 0;

  fixed_point_to_decimal_text #(
    .FRACTION_BITS       (FRACTION_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // decimal text of one number into text_buf
  function automatic void predict_text(input logic [VALUE_W-1:0] num,
                                       input logic [KREG_W-1:0] k_reg);
    logic [31:0]       whole;
    longint unsigned   scale;
    longint unsigned   frac_scaled;
    logic [CHAR_W-1:0] rev [10];
    int                n_int;
    int                k;
    whole = num[VALUE_W-1:FRACTION_BITS];
    k = (k_reg > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS : int'(k_reg);
    n_int = 0;
    // integer digits come out least significant first
    do begin
      rev[n_int] = ASCII_ZERO + CHAR_W'(whole % 10);
      whole = whole / 10;
      n_int++;
    end while (whole != 0);
    text_len = 0;
    for (int i = n_int - 1; i >= 0; i--) begin
      text_buf[text_len] = rev[i];
      text_len++;
    end
    if (k != 0) begin
      scale = 1;
      for (int j = 0; j < k; j++) scale = scale * 10;
      frac_scaled = (64'(num[FRACTION_BITS-1:0]) * scale) >> FRACTION_BITS;
      text_buf[text_len] = ASCII_DOT;
      // zero-padded to exactly k digits, filled from the right
      for (int i = k; i >= 1; i--) begin
        text_buf[text_len + i] = ASCII_ZERO + CHAR_W'(frac_scaled % 10);
        frac_scaled = frac_scaled / 10;
      end
      text_len = text_len + k + 1;
    end
  endfunction

  // typed-in text from the table: literal is right-aligned, skip the zero bytes
  function automatic void load_text(input text_t t);
    text_len = 0;
    for (int i = TEXT_MAX - 1; i >= 0; i--) begin
      if (t[8*i +: 8] != 8'h00) begin
        text_buf[text_len] = t[8*i +: 8];
        text_len++;
      end
    end
  endfunction

  function automatic void queue_text();
    text_char_t entry;
    for (int i = 0; i < text_len; i++) begin
      entry.ch   = text_buf[i];
      entry.last = (i == text_len - 1);
      expected_text.push_back(entry);
    end
  endfunction

  function automatic int pick_gap(input bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] random_number();
    logic [31:0]              whole;
    logic [FRACTION_BITS-1:0] frac;
    if ($urandom_range(0, 4) == 0) return {16'($urandom), $urandom};
    // spread the integer part over every digit count
    whole = $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: frac = '0;
      1: frac = '1;
      default: frac = FRACTION_BITS'($urandom);
    endcase
    return {whole, frac};
  endfunction

  // compare one accepted character with the oldest one owed
  function automatic void check_char();
    text_char_t want;
    if (expected_text.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected character %h last %b", character, last);
    end else begin
      want = expected_text.pop_front();
      if (character !== want.ch || last !== want.last) begin
        err_count++;
        if (err_count <= 10)
          $display("mismatch: character exp %h got %h, last exp %b got %b",
                   want.ch, character, want.last, last);
      end
    end
    checked_chars++;
  endfunction

  // one input transaction; returns at the edge where it is accepted
  task automatic send_number(input logic [VALUE_W-1:0] num);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // block drained: nothing owed and the pipeline given time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fraction_digits(input logic [PDATA_W-1:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRACTION_DIGITS_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frac_digits = data[KREG_W-1:0];
  endtask

  // receiver: check, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_char();
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && checked_chars >= HOLD_OFF_AFTER && in_valid) begin
        // long hold-off while the sender keeps offering, to back the block up
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(9, 29);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    number_row_t        row;
    logic [KREG_W-1:0]  k;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    value     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: first rows run on the reset setting
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.digits != frac_digits) write_fraction_digits(PDATA_W'(row.digits));
      send_number(row.number);
      if (row.text != '0) load_text(row.text);
      else predict_text(row.number, frac_digits);
      queue_text();
    end

    // random phases, each on its own setting; upper register bits get noise
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: k = 4'd9;
        1: k = 4'd0;
        4: k = 4'd15;
        default: k = KREG_W'($urandom_range(0, 15));
      endcase
      write_fraction_digits({28'($urandom), k});
      tx_gaps_on   = (phase != 2);
      rx_stalls_on = (phase != 3);
      for (int n = 0; n < PHASE_NUMBERS; n++) begin
        row.number = random_number();
        send_number(row.number);
        predict_text(row.number, frac_digits);
        queue_text();
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fptdt_pkg.sv
hw/rtl/fptdt_datapath.sv
hw/rtl/fptdt_ctrl.sv
hw/rtl/fixed_point_to_decimal_text.sv
test/tb.sv
